@@ design/lifo_index_pool_allocator_assert.svh @@
// assertion macros for the index pool allocator
`ifndef LIFO_INDEX_POOL_ALLOCATOR_ASSERT_SVH
`define LIFO_INDEX_POOL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define LIPA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed: same-cycle check");

// condition implies consequence in the next cycle
`define LIPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed: next-cycle check");

`else

`define LIPA_ASSERT_SAME(label, clk, rst, ante, cons)
`define LIPA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/lipa_pkg.sv @@
// shared types and constants of the index pool allocator
package lipa_pkg;

  localparam int INDEX_W    = 10;
  localparam int COUNT_W    = 11;
  localparam int PROOF_W    = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_STRAND  = 2'd2,
    ACT_QUERY   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CEILING   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NEVER     = 3'd3,
    ST_FREE      = 3'd4,
    ST_STRANDED  = 3'd5,
    ST_RETIRED   = 3'd6,
    ST_UNPROVEN  = 3'd7
  } status_t;

  typedef enum logic {
    CFG_LIVE_CEILING   = 1'b0,
    CFG_RECYCLE_ENABLE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_t;

  // per-index flags, kept together in one memory word
  typedef struct packed {
    logic retire;
    logic strand;
    logic free;
  } marks_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  localparam logic signed [PROOF_W-1:0] PROOF_VALID = 2'sd1;

endpackage

@@ design/lipa_ram.sv @@
// generic single-port-write ram with registered read
module lipa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/lipa_ctrl.sv @@
// controller: item sequencing and output handshake
module lipa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output lipa_pkg::ctrl_cmd_t cmd
);

  lipa_pkg::fsm_state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lipa_pkg::FSM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      lipa_pkg::FSM_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = lipa_pkg::FSM_EXEC;
        end
      end
      lipa_pkg::FSM_EXEC: begin
        // result slot empty or being emptied this edge
        cmd.commit = !out_valid || !out_stall;
        if (cmd.commit) begin
          state_next = lipa_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = lipa_pkg::FSM_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ design/lipa_dp.sv @@
// datapath: free stack, index flags, counters and result registers
module lipa_dp #(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lipa_pkg::ctrl_cmd_t                   cmd,
  input  logic                                  cfg_we,
  input  lipa_pkg::cfg_idx_t                    cfg_sel,
  input  logic [lipa_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic [1:0]                            action,
  input  logic [lipa_pkg::INDEX_W-1:0]          index,
  input  logic signed [lipa_pkg::PROOF_W-1:0]   zero_proof,
  output logic [2:0]                            status,
  output logic [lipa_pkg::INDEX_W-1:0]          granted_index,
  output logic                                  index_free,
  output logic                                  index_stranded,
  output logic                                  index_retired,
  output logic [lipa_pkg::COUNT_W-1:0]          live_count,
  output logic [lipa_pkg::COUNT_W-1:0]          peak_count,
  output logic [lipa_pkg::COUNT_W-1:0]          minted_count,
  output logic [lipa_pkg::COUNT_W-1:0]          free_count,
  output logic [lipa_pkg::COUNT_W-1:0]          stranded_count,
  output logic [lipa_pkg::COUNT_W-1:0]          retired_count
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int XW = (CW > lipa_pkg::COUNT_W) ? CW : lipa_pkg::COUNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

  // configuration
  logic [lipa_pkg::COUNT_W-1:0] live_ceiling;
  logic                         recycle_enable;

  // counters
  logic [CW-1:0] stack_top, stack_top_next;
  logic [CW-1:0] mint_counter, mint_counter_next;
  logic [CW-1:0] live_counter, live_counter_next;
  logic [CW-1:0] peak_counter, peak_counter_next;
  logic [CW-1:0] strand_counter, strand_counter_next;
  logic [CW-1:0] retire_counter, retire_counter_next;

  // captured item
  lipa_pkg::action_t                        act_q;
  logic [lipa_pkg::INDEX_W-1:0]             idx_q;
  logic signed [lipa_pkg::PROOF_W-1:0]      proof_q;

  // memories
  logic                          stack_we;
  logic [AW-1:0]                 stack_waddr;
  logic [lipa_pkg::INDEX_W-1:0]  stack_rdata;
  logic                          mark_we;
  logic [AW-1:0]                 mark_waddr;
  lipa_pkg::marks_t              mark_wdata;
  lipa_pkg::marks_t              mark_rdata;

  // step results
  lipa_pkg::status_t             held_status;
  lipa_pkg::status_t             res_status;
  logic [lipa_pkg::INDEX_W-1:0]  res_granted;
  lipa_pkg::marks_t              res_flags;
  logic                          minted;
  logic                          ceiling_hit;
  lipa_pkg::status_t             status_q;

  lipa_ram #(.WIDTH(lipa_pkg::INDEX_W), .DEPTH(POOL_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (idx_q),
    .re    (cmd.capture),
    .raddr (AW'(stack_top - 1'b1)),
    .rdata (stack_rdata)
  );

  lipa_ram #(.WIDTH($bits(lipa_pkg::marks_t)), .DEPTH(POOL_DEPTH)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (cmd.capture),
    .raddr (AW'(index)),
    .rdata (mark_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      live_ceiling   <= '0;
      recycle_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        lipa_pkg::CFG_LIVE_CEILING:   live_ceiling   <= cfg_wdata;
        lipa_pkg::CFG_RECYCLE_ENABLE: recycle_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q   <= lipa_pkg::action_t'(action);
      idx_q   <= index;
      proof_q <= zero_proof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_top      <= '0;
      mint_counter   <= '0;
      live_counter   <= '0;
      peak_counter   <= '0;
      strand_counter <= '0;
      retire_counter <= '0;
    end else if (cmd.commit) begin
      stack_top      <= stack_top_next;
      mint_counter   <= mint_counter_next;
      live_counter   <= live_counter_next;
      peak_counter   <= peak_counter_next;
      strand_counter <= strand_counter_next;
      retire_counter <= retire_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_q       <= res_status;
      granted_index  <= res_granted;
      index_free     <= res_flags.free;
      index_stranded <= res_flags.strand;
      index_retired  <= res_flags.retire;
    end
  end

  always_comb begin
    logic push_ok;
    logic pop_ok;

    stack_top_next      = stack_top;
    mint_counter_next   = mint_counter;
    live_counter_next   = live_counter;
    strand_counter_next = strand_counter;
    retire_counter_next = retire_counter;
    stack_we            = 1'b0;
    stack_waddr         = AW'(stack_top);
    mark_we             = 1'b0;
    mark_waddr          = AW'(idx_q);
    mark_wdata          = '0;
    res_status          = lipa_pkg::ST_OK;
    res_granted         = '0;
    res_flags           = '0;
    push_ok             = 1'b0;
    pop_ok              = 1'b0;

    // mint_counter never exceeds the pool depth, so this also bounds the index
    minted      = XW'(idx_q) < XW'(mint_counter);
    ceiling_hit = (live_ceiling != '0) && (XW'(live_counter) >= XW'(live_ceiling));

    if (!minted) begin
      held_status = lipa_pkg::ST_NEVER;
    end else if (mark_rdata.free) begin
      held_status = lipa_pkg::ST_FREE;
    end else if (mark_rdata.strand) begin
      held_status = lipa_pkg::ST_STRANDED;
    end else if (mark_rdata.retire) begin
      held_status = lipa_pkg::ST_RETIRED;
    end else begin
      held_status = lipa_pkg::ST_OK;
    end

    unique case (act_q)
      lipa_pkg::ACT_ACQUIRE: begin
        if (ceiling_hit) begin
          res_status = lipa_pkg::ST_CEILING;
        end else if (stack_top != '0) begin
          // a popped index holds only its free flag, so clear the whole word
          pop_ok         = 1'b1;
          stack_top_next = stack_top - 1'b1;
          res_granted    = stack_rdata;
          mark_we        = 1'b1;
          mark_waddr     = AW'(stack_rdata);
        end else if (mint_counter == DEPTH_C) begin
          res_status = lipa_pkg::ST_FULL;
        end else begin
          pop_ok            = 1'b1;
          mint_counter_next = mint_counter + 1'b1;
          res_granted       = lipa_pkg::INDEX_W'(mint_counter);
          mark_we           = 1'b1;
          mark_waddr        = AW'(mint_counter);
        end
        if (pop_ok) begin
          live_counter_next = live_counter + 1'b1;
        end
      end
      lipa_pkg::ACT_RELEASE: begin
        res_status = held_status;
        if (held_status == lipa_pkg::ST_OK && proof_q != lipa_pkg::PROOF_VALID) begin
          res_status = lipa_pkg::ST_UNPROVEN;
        end
        if (res_status == lipa_pkg::ST_OK) begin
          if (!recycle_enable) begin
            mark_we             = 1'b1;
            mark_wdata.retire   = 1'b1;
            retire_counter_next = retire_counter + 1'b1;
          end else if (stack_top != DEPTH_C) begin
            push_ok         = 1'b1;
            mark_we         = 1'b1;
            mark_wdata.free = 1'b1;
            stack_we        = 1'b1;
            stack_top_next  = stack_top + 1'b1;
          end
          if (push_ok && live_counter != '0) begin
            live_counter_next = live_counter - 1'b1;
          end
        end
      end
      lipa_pkg::ACT_STRAND: begin
        res_status = held_status;
        if (held_status == lipa_pkg::ST_OK) begin
          mark_we             = 1'b1;
          mark_wdata.strand   = 1'b1;
          strand_counter_next = strand_counter + 1'b1;
        end
      end
      lipa_pkg::ACT_QUERY: begin
        if (minted) begin
          res_flags = mark_rdata;
        end
      end
      default: ;
    endcase

    peak_counter_next = (live_counter_next > peak_counter) ? live_counter_next : peak_counter;

    stack_we = stack_we && cmd.commit;
    mark_we  = mark_we && cmd.commit;
  end

  assign status         = status_q;
  assign live_count     = lipa_pkg::COUNT_W'(live_counter);
  assign peak_count     = lipa_pkg::COUNT_W'(peak_counter);
  assign minted_count   = lipa_pkg::COUNT_W'(mint_counter);
  assign free_count     = lipa_pkg::COUNT_W'(stack_top);
  assign stranded_count = lipa_pkg::COUNT_W'(strand_counter);
  assign retired_count  = lipa_pkg::COUNT_W'(retire_counter);

endmodule

@@ design/lifo_index_pool_allocator.sv @@
// top level of the lifo index pool allocator
//
// hands out indices from a lifo free stack, minting fresh ones when it is empty
// input channel: in_valid / in_stall with action, index and zero_proof; an item
//   is taken at a clock edge where in_valid is high and in_stall is low
// output channel: out_valid / out_stall with status, granted index, query flags
//   and all six counters; one result item per input item, in order
// config channel: cfg_valid / cfg_ready (always ready), cfg_index selects the
//   live ceiling (0) or recycle enable (1), cfg_data carries the value
// the result is registered: the controller takes the item in idle, moves to exec
//   and commits it into the result slot there once the slot is free; no new item
//   is taken until then, since exec waits on the registered read of the free stack
//   and flag memories, and the next item needs the stack pointer that this one leaves
// a stalled result holds; the block finishes the item in hand and then waits
//   in exec with in_stall high until the result slot frees
// reset (rst, synchronous): counters, stack pointer and config go to their reset
//   values; memories are not cleared, since every read is gated by the minted
//   count or the stack pointer, so there is no clearing pass
module lifo_index_pool_allocator #(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic [lipa_pkg::INDEX_W-1:0]        index,
  input  logic signed [lipa_pkg::PROOF_W-1:0] zero_proof,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          status,
  output logic [lipa_pkg::INDEX_W-1:0]        granted_index,
  output logic                                index_free,
  output logic                                index_stranded,
  output logic                                index_retired,
  output logic [lipa_pkg::COUNT_W-1:0]        live_count,
  output logic [lipa_pkg::COUNT_W-1:0]        peak_count,
  output logic [lipa_pkg::COUNT_W-1:0]        minted_count,
  output logic [lipa_pkg::COUNT_W-1:0]        free_count,
  output logic [lipa_pkg::COUNT_W-1:0]        stranded_count,
  output logic [lipa_pkg::COUNT_W-1:0]        retired_count,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [lipa_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "lifo_index_pool_allocator_assert.svh"

  lipa_pkg::ctrl_cmd_t cmd;

  // register writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // sequencing: idle takes an item, exec commits it into the result slot
  lipa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // stack and flag memories, counters, config registers, result registers
  lipa_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_sel        (lipa_pkg::cfg_idx_t'(cfg_index)),
    .cfg_wdata      (cfg_data),
    .action         (action),
    .index          (index),
    .zero_proof     (zero_proof),
    .status         (status),
    .granted_index  (granted_index),
    .index_free     (index_free),
    .index_stranded (index_stranded),
    .index_retired  (index_retired),
    .live_count     (live_count),
    .peak_count     (peak_count),
    .minted_count   (minted_count),
    .free_count     (free_count),
    .stranded_count (stranded_count),
    .retired_count  (retired_count)
  );

  // a taken item keeps the input side closed for the next cycle
  `LIPA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // a commit never overwrites a result that is still waiting
  `LIPA_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.commit, !(out_valid && out_stall))
  // every commit leaves a result on the output
  `LIPA_ASSERT_NEXT(a_commit_shows, clk, rst, cmd.commit, out_valid)

endmodule

@@ tb/tb_lifo_index_pool_allocator.sv @@
// self-checking testbench for the lifo index pool allocator
module tb_lifo_index_pool_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_DEPTH  = 1024;
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off for the pressure phase
  localparam int HOLD_ITEMS  = 60;      // items offered while the receiver holds off
  localparam int CYCLE_LIMIT = 200000;  // generous watchdog, slowest legal run is far below

  // one result item as the block reports it
  typedef struct packed {
    lipa_pkg::status_t                 status;
    logic [lipa_pkg::INDEX_W-1:0]      granted;
    logic                              q_free;
    logic                              q_strand;
    logic                              q_retire;
    logic [lipa_pkg::COUNT_W-1:0]      live;
    logic [lipa_pkg::COUNT_W-1:0]      peak;
    logic [lipa_pkg::COUNT_W-1:0]      minted;
    logic [lipa_pkg::COUNT_W-1:0]      free_n;
    logic [lipa_pkg::COUNT_W-1:0]      strand_n;
    logic [lipa_pkg::COUNT_W-1:0]      retire_n;
  } alloc_result_t;

  // clock, reset and all block inputs start at known values
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                 in_valid   = 1'b0;
  logic                                 in_stall;
  logic [1:0]                           action     = lipa_pkg::ACT_QUERY;
  logic [lipa_pkg::INDEX_W-1:0]         index      = '0;
  logic signed [lipa_pkg::PROOF_W-1:0]  zero_proof = '0;

  logic                                 out_valid;
  logic                                 out_stall  = 1'b0;
  logic [2:0]                           status;
  logic [lipa_pkg::INDEX_W-1:0]         granted_index;
  logic                                 index_free;
  logic                                 index_stranded;
  logic                                 index_retired;
  logic [lipa_pkg::COUNT_W-1:0]         live_count;
  logic [lipa_pkg::COUNT_W-1:0]         peak_count;
  logic [lipa_pkg::COUNT_W-1:0]         minted_count;
  logic [lipa_pkg::COUNT_W-1:0]         free_count;
  logic [lipa_pkg::COUNT_W-1:0]         stranded_count;
  logic [lipa_pkg::COUNT_W-1:0]         retired_count;

  logic                                 cfg_valid  = 1'b0;
  logic                                 cfg_ready;
  logic                                 cfg_index  = lipa_pkg::CFG_LIVE_CEILING;
  logic [lipa_pkg::CFG_DATA_W-1:0]      cfg_data   = '0;

  // predictor copy of the allocator state
  logic [lipa_pkg::INDEX_W-1:0] free_stack_copy [POOL_DEPTH];
  bit                           free_mark   [POOL_DEPTH];
  bit                           strand_mark [POOL_DEPTH];
  bit                           retire_mark [POOL_DEPTH];
  int unsigned                  stack_depth;
  int unsigned                  mint_total;
  int unsigned                  live_total;
  int unsigned                  peak_total;
  int unsigned                  strand_total;
  int unsigned                  retire_total;
  logic [lipa_pkg::COUNT_W-1:0] ceiling_reg = '0;
  bit                           recycle_reg = 1'b1;

  // results still owed by the block, oldest first
  alloc_result_t pending_results [$];

  int  items_sent    = 0;
  int  items_checked = 0;
  int  mismatches    = 0;
  int  cycle_count   = 0;
  bit  quiet         = 1'b0;  // no random idling on either side while set
  bit  stall_hold    = 1'b0;  // receiver hold-off in progress
  event hold_kick;

  lifo_index_pool_allocator #(
    .POOL_DEPTH(POOL_DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .index         (index),
    .zero_proof    (zero_proof),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .granted_index (granted_index),
    .index_free    (index_free),
    .index_stranded(index_stranded),
    .index_retired (index_retired),
    .live_count    (live_count),
    .peak_count    (peak_count),
    .minted_count  (minted_count),
    .free_count    (free_count),
    .stranded_count(stranded_count),
    .retired_count (retired_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // predict one item and advance the predictor state
  function automatic alloc_result_t predict_allocation(lipa_pkg::action_t act,
                                                       logic [lipa_pkg::INDEX_W-1:0] idx,
                                                       logic signed [lipa_pkg::PROOF_W-1:0] proof);
    alloc_result_t r;
    r = '0;
    r.status = lipa_pkg::ST_OK;
    case (act) inside
      lipa_pkg::ACT_ACQUIRE: begin
        // ceiling wins over pool full
        if (ceiling_reg != 0 && live_total >= ceiling_reg) begin
          r.status = lipa_pkg::ST_CEILING;
        end else if (stack_depth > 0) begin
          // lifo: most recently released index comes back first
          stack_depth--;
          r.granted = free_stack_copy[stack_depth];
          free_mark[r.granted] = 1'b0;
        end else if (mint_total >= POOL_DEPTH) begin
          r.status = lipa_pkg::ST_FULL;
        end else begin
          r.granted = lipa_pkg::INDEX_W'(mint_total);
          free_mark[r.granted]   = 1'b0;
          strand_mark[r.granted] = 1'b0;
          retire_mark[r.granted] = 1'b0;
          mint_total++;
        end
        if (r.status == lipa_pkg::ST_OK) begin
          live_total++;
          if (live_total > peak_total) peak_total = live_total;
        end
      end
      lipa_pkg::ACT_RELEASE, lipa_pkg::ACT_STRAND: begin
        // shared check order: never minted, free, stranded, retired
        if (idx >= mint_total) r.status = lipa_pkg::ST_NEVER;
        else if (free_mark[idx]) r.status = lipa_pkg::ST_FREE;
        else if (strand_mark[idx]) r.status = lipa_pkg::ST_STRANDED;
        else if (retire_mark[idx]) r.status = lipa_pkg::ST_RETIRED;
        if (act == lipa_pkg::ACT_RELEASE && r.status == lipa_pkg::ST_OK &&
            proof != lipa_pkg::PROOF_VALID) begin
          r.status = lipa_pkg::ST_UNPROVEN;
        end
        if (r.status == lipa_pkg::ST_OK) begin
          if (act == lipa_pkg::ACT_STRAND) begin
            strand_mark[idx] = 1'b1;
            strand_total++;
          end else if (!recycle_reg) begin
            // retired indices stay counted live
            retire_mark[idx] = 1'b1;
            retire_total++;
          end else if (stack_depth < POOL_DEPTH) begin
            free_mark[idx] = 1'b1;
            free_stack_copy[stack_depth] = idx;
            stack_depth++;
            if (live_total > 0) live_total--;
          end
        end
      end
      default: begin
        // unminted query reports ok with all flags clear
        if (idx < mint_total) begin
          r.q_free   = free_mark[idx];
          r.q_strand = strand_mark[idx];
          r.q_retire = retire_mark[idx];
        end
      end
    endcase
    r.live     = lipa_pkg::COUNT_W'(live_total);
    r.peak     = lipa_pkg::COUNT_W'(peak_total);
    r.minted   = lipa_pkg::COUNT_W'(mint_total);
    r.free_n   = lipa_pkg::COUNT_W'(stack_depth);
    r.strand_n = lipa_pkg::COUNT_W'(strand_total);
    r.retire_n = lipa_pkg::COUNT_W'(retire_total);
    return r;
  endfunction

  // present one item and hold it until the block takes it; valid stays high afterwards
  task automatic offer_request(lipa_pkg::action_t act, logic [lipa_pkg::INDEX_W-1:0] idx,
                               logic signed [lipa_pkg::PROOF_W-1:0] proof);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    index      <= idx;
    zero_proof <= proof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_allocation(act, idx, proof));
    items_sent++;
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // register writes only while the block is idle; both registers every time
  task automatic configure(logic [lipa_pkg::COUNT_W-1:0] ceil, bit recycle);
    drain_results;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= lipa_pkg::CFG_LIVE_CEILING;
    cfg_data  <= ceil;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ceiling_reg = ceil;
    cfg_index <= lipa_pkg::CFG_RECYCLE_ENABLE;
    cfg_data  <= lipa_pkg::CFG_DATA_W'(recycle);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    recycle_reg = recycle;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string what, logic [lipa_pkg::COUNT_W-1:0] want_v,
                             logic [lipa_pkg::COUNT_W-1:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: result %0d %s mismatch, expected %0d, actual %0d",
               $time, items_checked, what, want_v, got_v);
    end
  endtask

  // result side: compare each taken item with the oldest prediction, drive stall
  always @(posedge clk) begin : result_monitor
    alloc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result item, expected none, actual status %0d",
                 $time, status);
      end else begin
        want = pending_results.pop_front();
        check_field("status",         want.status,   status);
        check_field("granted_index",  want.granted,  granted_index);
        check_field("index_free",     want.q_free,   index_free);
        check_field("index_stranded", want.q_strand, index_stranded);
        check_field("index_retired",  want.q_retire, index_retired);
        check_field("live_count",     want.live,     live_count);
        check_field("peak_count",     want.peak,     peak_count);
        check_field("minted_count",   want.minted,   minted_count);
        check_field("free_count",     want.free_n,   free_count);
        check_field("stranded_count", want.strand_n, stranded_count);
        check_field("retired_count",  want.retire_n, retired_count);
      end
      items_checked++;
    end
    out_stall <= stall_hold || (!quiet && $urandom_range(99) < 9);
  end

  // long receiver hold-off, counted here so the sender keeps offering meanwhile
  initial begin : pressure_hold
    forever begin
      @(hold_kick);
      @(posedge clk);
      stall_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      stall_hold <= 1'b0;
    end
  end

  // each error code but pool full, the flag queries, lifo order, ceiling and recycle off
  task automatic test_directed_cases;
    offer_request(lipa_pkg::ACT_QUERY,   10'd0,    lipa_pkg::PROOF_VALID); // unminted query
    offer_request(lipa_pkg::ACT_RELEASE, 10'd1023, lipa_pkg::PROOF_VALID); // never minted
    offer_request(lipa_pkg::ACT_STRAND,  10'd5,    lipa_pkg::PROOF_VALID); // never minted
    offer_request(lipa_pkg::ACT_ACQUIRE, 10'd1023, 2'sd0);        // mints 0, index ignored
    offer_request(lipa_pkg::ACT_ACQUIRE, 10'd0,    -2'sd2);       // mints 1
    offer_request(lipa_pkg::ACT_ACQUIRE, 10'd0,    2'sd0);        // mints 2
    offer_request(lipa_pkg::ACT_RELEASE, 10'd1,    2'sd0);        // zero proof
    offer_request(lipa_pkg::ACT_RELEASE, 10'd1,    -2'sd1);       // negative proof
    offer_request(lipa_pkg::ACT_RELEASE, 10'd1,    -2'sd2);       // most negative proof
    offer_request(lipa_pkg::ACT_RELEASE, 10'd1,    lipa_pkg::PROOF_VALID); // pushed on stack
    offer_request(lipa_pkg::ACT_RELEASE, 10'd1,    lipa_pkg::PROOF_VALID); // already free
    offer_request(lipa_pkg::ACT_QUERY,   10'd1,    2'sd0);        // free flag
    offer_request(lipa_pkg::ACT_STRAND,  10'd1,    2'sd0);        // strand of a free index
    offer_request(lipa_pkg::ACT_ACQUIRE, 10'd0,    2'sd0);        // pops 1 back
    offer_request(lipa_pkg::ACT_STRAND,  10'd2,    2'sd0);        // strand ok
    offer_request(lipa_pkg::ACT_STRAND,  10'd2,    2'sd0);        // already stranded
    offer_request(lipa_pkg::ACT_RELEASE, 10'd2,    lipa_pkg::PROOF_VALID); // stranded
    offer_request(lipa_pkg::ACT_QUERY,   10'd2,    2'sd0);        // stranded flag
    offer_request(lipa_pkg::ACT_RELEASE, 10'd1,    lipa_pkg::PROOF_VALID); // back on stack
    configure(11'd2, 1'b0);
    offer_request(lipa_pkg::ACT_ACQUIRE, 10'd0,    2'sd0);        // live at ceiling
    configure(11'd0, 1'b0);
    offer_request(lipa_pkg::ACT_ACQUIRE, 10'd0,    2'sd0);        // pops with recycling off
    offer_request(lipa_pkg::ACT_RELEASE, 10'd0,    lipa_pkg::PROOF_VALID); // retires 0
    offer_request(lipa_pkg::ACT_RELEASE, 10'd0,    lipa_pkg::PROOF_VALID); // already retired
    offer_request(lipa_pkg::ACT_STRAND,  10'd0,    2'sd0);        // strand of retired
    offer_request(lipa_pkg::ACT_QUERY,   10'd0,    2'sd0);        // retired flag
    offer_request(lipa_pkg::ACT_QUERY,   10'd1023, -2'sd1);       // top index, unminted
    configure(11'd0, 1'b1);
  endtask

  // mostly well-formed traffic on minted indices, some noise on any index
  task automatic test_random_traffic(int count, int quiet_items);
    lipa_pkg::action_t                   act;
    logic [lipa_pkg::INDEX_W-1:0]        idx;
    logic signed [lipa_pkg::PROOF_W-1:0] proof;
    logic [lipa_pkg::COUNT_W-1:0]        ceil;
    int                                  pick;
    quiet <= (quiet_items > 0);
    for (int k = 0; k < count; k++) begin
      if (quiet_items > 0 && k == quiet_items) quiet <= 1'b0;
      if (k % 100 == 0) begin
        // sweep ceilings: none, tight against live, extremes of the register
        case ($urandom_range(5))
          0:       ceil = '0;
          1:       ceil = 11'd1;
          2:       ceil = 11'd1024;
          3:       ceil = 11'd2047;
          default: ceil = lipa_pkg::COUNT_W'(live_total + $urandom_range(8));
        endcase
        configure(ceil, bit'($urandom_range(1)));
      end
      pick = $urandom_range(99);
      if (pick < 35) act = lipa_pkg::ACT_ACQUIRE;
      else if (pick < 70) act = lipa_pkg::ACT_RELEASE;
      else if (pick < 80) act = lipa_pkg::ACT_STRAND;
      else act = lipa_pkg::ACT_QUERY;
      if (mint_total > 0 && $urandom_range(99) < 75) begin
        idx = lipa_pkg::INDEX_W'($urandom_range(mint_total - 1));
      end else begin
        idx = lipa_pkg::INDEX_W'($urandom_range(POOL_DEPTH - 1));
      end
      proof = ($urandom_range(99) < 80) ? lipa_pkg::PROOF_VALID
                                         : lipa_pkg::PROOF_W'($urandom_range(3));
      offer_request(act, idx, proof);
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_receiver_hold;
    lipa_pkg::action_t            act;
    logic [lipa_pkg::INDEX_W-1:0] idx;
    configure(11'd0, 1'b1);
    -> hold_kick;
    for (int n = 0; n < HOLD_ITEMS; n++) begin
      act = (n % 3 == 2) ? lipa_pkg::ACT_RELEASE : lipa_pkg::ACT_ACQUIRE;
      if (mint_total > 0) begin
        idx = lipa_pkg::INDEX_W'($urandom_range(mint_total - 1));
      end else begin
        idx = '0;
      end
      offer_request(act, idx, lipa_pkg::PROOF_VALID);
    end
  endtask

  initial begin : test_sequence
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases;
    test_random_traffic(200, 100);
    test_receiver_hold;
    test_random_traffic(200, 0);
    drain_results;
    repeat (4) @(posedge clk);
    $display("covered every action, each status code but pool full, lifo reuse,");
    $display("ceilings 0..2047, recycle on and off and a long receiver hold-off");
    $display("items sent %0d, results checked %0d, mismatches %0d",
             items_sent, items_checked, mismatches);
    if (mismatches == 0) begin
      $display("** lifo_index_pool_allocator: PASSED **");
    end else begin
      $display("** lifo_index_pool_allocator: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results pending", $time, pending_results.size());
    $display("** lifo_index_pool_allocator: FAILED **");
    $finish;
  end

endmodule

@@ lifo_index_pool_allocator.f @@
+incdir+design
design/lipa_pkg.sv
design/lipa_ram.sv
design/lipa_ctrl.sv
design/lipa_dp.sv
design/lifo_index_pool_allocator.sv
tb/tb_lifo_index_pool_allocator.sv
